/* hw/rtl/sdq_pkg.sv */
package sdq_pkg;

	localparam int ISSUE_DEPTH  = 8;
	localparam int DECODE_DEPTH = 4;
	localparam int EXEC_DEPTH   = 4;
	localparam int MAX_OUT      = 4;

	localparam int IQ_CW = $clog2(ISSUE_DEPTH + 1);
	localparam int DQ_CW = $clog2(DECODE_DEPTH + 1);
	localparam int EQ_CW = $clog2(EXEC_DEPTH + 1);
	localparam int MAX_DEPTH = (ISSUE_DEPTH > DECODE_DEPTH) ?
		((ISSUE_DEPTH > EXEC_DEPTH) ? ISSUE_DEPTH : EXEC_DEPTH) :
		((DECODE_DEPTH > EXEC_DEPTH) ? DECODE_DEPTH : EXEC_DEPTH);
	localparam int SCAN_W = $clog2(MAX_DEPTH + 1);
	localparam int NOUT_W = $clog2(MAX_OUT + 1);

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_ISSUE = 1'b1;

	localparam logic [1:0] KIND_DONE   = 2'd0;
	localparam logic [1:0] KIND_ACCEPT = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	localparam logic [1:0] REG_WIDTH    = 2'd0;
	localparam logic [1:0] REG_DEC_LAT  = 2'd1;
	localparam logic [1:0] REG_EXEC_LAT = 2'd2;

	typedef struct packed {
		logic [7:0] tag;
		logic       ends;
		logic [7:0] wait_cnt;
	} entry_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic dec;
	} cell_ctl_t;

endpackage

/* hw/rtl/sdq_cell.sv */
module sdq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  sdq_pkg::cell_ctl_t ctl,
	input  sdq_pkg::entry_t    din,
	input  sdq_pkg::entry_t    nxt,
	output sdq_pkg::entry_t    q
);

	sdq_pkg::entry_t e_q;

	assign q = e_q;

	// load wins over shift; count down only when neither moves the slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q <= '0;
		end else if (ctl.load) begin
			e_q <= din;
		end else if (ctl.shift) begin
			e_q <= nxt;
		end else if (ctl.dec && e_q.wait_cnt != 8'd0) begin
			e_q.wait_cnt <= e_q.wait_cnt - 8'd1;
		end
	end

endmodule

/* hw/rtl/simd_stage_timing_queues.sv */
// channel | dir | handshake          | payload
// s_*     | in  | s_tvalid/s_tready  | tuser opcode, tlast ends_warp, tdata tag/delay
// m_*     | out | m_tvalid/m_tready  | tuser kind, tlast last, tdata tag/warp_done
// apb     | in  | psel/penable       | stage_width, decode_latency, exec_latency
// A tick beat runs the completion, execute and decode scans, then a countdown step;
// each scan walks the execute, decode or issue queue fill taken at its start and pops
// one entry a cycle off the head of its cell row; the completion scan stalls while a
// completion waits on m_tready. Reset empties all queues and loads the register defaults.
module simd_stage_timing_queues (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [7:0] op_tag, [15:8] ready_delay
	input  logic        s_tuser,  // [0] opcode
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [7:0] done_tag, [8] warp_done, rest zero
	output logic [1:0]  m_tuser,  // [1:0] kind
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [2:0] {IDLE, COMP, EXEC, DECD, CNTD} state_t;

	state_t state_q;
	logic [4:0] width_q;
	logic [7:0] dec_lat_q, exec_lat_q;
	logic [sdq_pkg::IQ_CW-1:0] iq_cnt_q;
	logic [sdq_pkg::DQ_CW-1:0] dq_cnt_q;
	logic [sdq_pkg::EQ_CW-1:0] eq_cnt_q;
	logic [sdq_pkg::SCAN_W-1:0] idx_q, total_q;
	logic [sdq_pkg::NOUT_W-1:0] nout_q;
	sdq_pkg::entry_t pend_q;
	logic pend_v_q;
	logic out_v_q;
	logic [15:0] out_data_q;
	logic [1:0] out_kind_q;
	logic out_last_q;

	sdq_pkg::entry_t iq [sdq_pkg::ISSUE_DEPTH];
	sdq_pkg::entry_t dq [sdq_pkg::DECODE_DEPTH];
	sdq_pkg::entry_t eq [sdq_pkg::EXEC_DEPTH];

	logic iq_pop, iq_push, dq_pop, dq_push, eq_pop, eq_push, dec_all;
	sdq_pkg::entry_t iq_din, dq_din, eq_din;
	logic [sdq_pkg::IQ_CW-1:0] iq_wr;
	logic [sdq_pkg::DQ_CW-1:0] dq_wr;
	logic [sdq_pkg::EQ_CW-1:0] eq_wr;

	logic out_free, s_acc, cfg_wr, scan_end, emit, step_ok, mv;

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite;
	assign out_free = !out_v_q || m_tready;
	assign s_tready = (state_q == IDLE) && out_free;
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign scan_end = (idx_q == total_q);

	always_comb begin
		unique case (paddr[3:2])
			sdq_pkg::REG_WIDTH:    prdata = {27'd0, width_q};
			sdq_pkg::REG_DEC_LAT:  prdata = {24'd0, dec_lat_q};
			sdq_pkg::REG_EXEC_LAT: prdata = {24'd0, exec_lat_q};
			default:               prdata = '0;
		endcase
	end

	assign emit = (state_q == COMP) && !scan_end && (eq[0].wait_cnt == 8'd0) &&
		(nout_q < sdq_pkg::NOUT_W'(sdq_pkg::MAX_OUT));
	assign step_ok = !(emit && pend_v_q && !out_free);

	always_comb begin
		iq_pop = 1'b0; iq_push = 1'b0; iq_din = iq[0];
		dq_pop = 1'b0; dq_push = 1'b0; dq_din = dq[0];
		eq_pop = 1'b0; eq_push = 1'b0; eq_din = eq[0];
		dec_all = 1'b0;
		mv = 1'b0;
		unique case (state_q)
			IDLE: begin
				if (s_acc && s_tuser == sdq_pkg::OP_ISSUE &&
					iq_cnt_q < sdq_pkg::IQ_CW'(sdq_pkg::ISSUE_DEPTH)) begin
					iq_push = 1'b1;
					iq_din  = '{tag: s_tdata[7:0], ends: s_tlast, wait_cnt: s_tdata[15:8]};
				end
			end
			COMP: begin
				if (!scan_end && step_ok) begin
					eq_pop  = 1'b1;
					eq_push = !emit;
				end
			end
			EXEC: begin
				if (!scan_end) begin
					mv = (dq[0].wait_cnt == 8'd0) && (8'(idx_q) < 8'(width_q)) &&
						(eq_cnt_q < sdq_pkg::EQ_CW'(sdq_pkg::EXEC_DEPTH));
					dq_pop = 1'b1;
					if (mv) begin
						eq_push = 1'b1;
						eq_din  = dq[0];
						eq_din.wait_cnt = exec_lat_q;
					end else begin
						dq_push = 1'b1;
					end
				end
			end
			DECD: begin
				if (!scan_end) begin
					mv = (iq[0].wait_cnt == 8'd0) && (8'(idx_q) < 8'(width_q)) &&
						(dq_cnt_q < sdq_pkg::DQ_CW'(sdq_pkg::DECODE_DEPTH));
					iq_pop = 1'b1;
					if (mv) begin
						dq_push = 1'b1;
						dq_din  = iq[0];
						dq_din.wait_cnt = dec_lat_q;
					end else begin
						iq_push = 1'b1;
					end
				end
			end
			CNTD: dec_all = 1'b1;
			default: ;
		endcase
	end

	assign iq_wr = iq_pop ? iq_cnt_q - 1'b1 : iq_cnt_q;
	assign dq_wr = dq_pop ? dq_cnt_q - 1'b1 : dq_cnt_q;
	assign eq_wr = eq_pop ? eq_cnt_q - 1'b1 : eq_cnt_q;

	for (genvar k = 0; k < sdq_pkg::ISSUE_DEPTH; k++) begin : g_iq
		sdq_pkg::cell_ctl_t c;
		assign c = '{load: iq_push && iq_wr == sdq_pkg::IQ_CW'(k), shift: iq_pop,
			dec: dec_all};
		sdq_cell u_cell (.clk, .arst_n, .ctl(c), .din(iq_din),
			.nxt(iq[(k + 1 < sdq_pkg::ISSUE_DEPTH) ? k + 1 : k]), .q(iq[k]));
	end

	for (genvar k = 0; k < sdq_pkg::DECODE_DEPTH; k++) begin : g_dq
		sdq_pkg::cell_ctl_t c;
		assign c = '{load: dq_push && dq_wr == sdq_pkg::DQ_CW'(k), shift: dq_pop,
			dec: dec_all};
		sdq_cell u_cell (.clk, .arst_n, .ctl(c), .din(dq_din),
			.nxt(dq[(k + 1 < sdq_pkg::DECODE_DEPTH) ? k + 1 : k]), .q(dq[k]));
	end

	for (genvar k = 0; k < sdq_pkg::EXEC_DEPTH; k++) begin : g_eq
		sdq_pkg::cell_ctl_t c;
		assign c = '{load: eq_push && eq_wr == sdq_pkg::EQ_CW'(k), shift: eq_pop,
			dec: dec_all};
		sdq_cell u_cell (.clk, .arst_n, .ctl(c), .din(eq_din),
			.nxt(eq[(k + 1 < sdq_pkg::EXEC_DEPTH) ? k + 1 : k]), .q(eq[k]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= 5'd4;
			dec_lat_q  <= 8'd1;
			exec_lat_q <= 8'd4;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				sdq_pkg::REG_WIDTH:    width_q    <= pwdata[4:0];
				sdq_pkg::REG_DEC_LAT:  dec_lat_q  <= pwdata[7:0];
				sdq_pkg::REG_EXEC_LAT: exec_lat_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			iq_cnt_q <= '0;
			dq_cnt_q <= '0;
			eq_cnt_q <= '0;
			idx_q    <= '0;
			total_q  <= '0;
			nout_q   <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			pend_q   <= '0;
			out_data_q <= '0;
			out_kind_q <= '0;
			out_last_q <= 1'b0;
		end else begin
			iq_cnt_q <= iq_cnt_q + sdq_pkg::IQ_CW'(iq_push) - sdq_pkg::IQ_CW'(iq_pop);
			dq_cnt_q <= dq_cnt_q + sdq_pkg::DQ_CW'(dq_push) - sdq_pkg::DQ_CW'(dq_pop);
			eq_cnt_q <= eq_cnt_q + sdq_pkg::EQ_CW'(eq_push) - sdq_pkg::EQ_CW'(eq_pop);
			if (m_tready) out_v_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (s_acc) begin
						if (s_tuser == sdq_pkg::OP_ISSUE) begin
							out_v_q    <= 1'b1;
							out_kind_q <= (iq_cnt_q < sdq_pkg::IQ_CW'(sdq_pkg::ISSUE_DEPTH)) ?
								sdq_pkg::KIND_ACCEPT : sdq_pkg::KIND_REJECT;
							out_data_q <= {8'd0, s_tdata[7:0]};
							out_last_q <= 1'b1;
						end else begin
							state_q <= COMP;
							idx_q   <= '0;
							total_q <= sdq_pkg::SCAN_W'(eq_cnt_q);
							nout_q  <= '0;
						end
					end
				end
				COMP: begin
					if (scan_end) begin
						// flush the held completion as the final beat
						if (!pend_v_q || out_free) begin
							if (pend_v_q) begin
								out_v_q    <= 1'b1;
								out_kind_q <= sdq_pkg::KIND_DONE;
								out_data_q <= {7'd0, pend_q.ends, pend_q.tag};
								out_last_q <= 1'b1;
							end
							pend_v_q <= 1'b0;
							state_q  <= EXEC;
							idx_q    <= '0;
							total_q  <= sdq_pkg::SCAN_W'(dq_cnt_q);
						end
					end else if (step_ok) begin
						idx_q <= idx_q + 1'b1;
						if (emit) begin
							if (pend_v_q) begin
								out_v_q    <= 1'b1;
								out_kind_q <= sdq_pkg::KIND_DONE;
								out_data_q <= {7'd0, pend_q.ends, pend_q.tag};
								out_last_q <= 1'b0;
							end
							pend_q   <= eq[0];
							pend_v_q <= 1'b1;
							nout_q   <= nout_q + 1'b1;
						end
					end
				end
				EXEC: begin
					if (scan_end) begin
						state_q <= DECD;
						idx_q   <= '0;
						total_q <= sdq_pkg::SCAN_W'(iq_cnt_q);
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				DECD: begin
					if (scan_end) state_q <= CNTD;
					else idx_q <= idx_q + 1'b1;
				end
				CNTD: state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

	a_iq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		iq_cnt_q <= sdq_pkg::IQ_CW'(sdq_pkg::ISSUE_DEPTH)) else $error("issue overflow");
	a_eq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		eq_cnt_q <= sdq_pkg::EQ_CW'(sdq_pkg::EXEC_DEPTH)) else $error("exec overflow");
	a_pend_comp: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> state_q == COMP) else $error("held completion outside scan");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != IDLE |-> !s_tready) else $error("ready while busy");

endmodule
